// ----- sv/pidaw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and constants for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN_PROP       = 3'd0,
    REG_GAIN_INT_STEP   = 3'd1,
    REG_GAIN_DERIV_STEP = 3'd2,
    REG_TARGET_VALUE    = 3'd3,
    REG_DRIVE_FLOOR     = 3'd4,
    REG_DRIVE_CEILING   = 3'd5
  } reg_index_t;

  // Reset value of the drive ceiling
  localparam logic signed [15:0] CEILING_RESET = 16'sd511;

  // Datapath widths (Q8.8 inputs, Q16.16 products)
  localparam int unsigned ERR_W   = 17;
  localparam int unsigned DIFF_W  = 18;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned TOTAL_W = 51;
  localparam int unsigned FRAC_W  = 16;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Clamp status codes on the result
  typedef enum logic [1:0] {
    CLAMP_NONE    = 2'd0,
    CLAMP_CEILING = 2'd1,
    CLAMP_FLOOR   = 2'd2
  } clamp_status_t;

endpackage

// ----- sv/pid_antiwindup_controller_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_antiwindup_controller_unit
// Positional PID step with saturating error sum and conditional anti-windup.
// ----------------------------------------------------------------------------
// Each accepted measurement is captured in an input register; when it
// advances, the error, saturated sum, three gain products, clamp and
// state update are evaluated in one pass and the result is loaded into
// the output register. The block takes one item per cycle while the
// output is not stalled. The throughput is set by the error-sum feedback
// loop, which closes through the integral multiply (16 x 32 bits) and the
// clamp compare with no register between. A clear item zeroes the error
// sum and previous error and gives no result. Write configuration only
// while no item is in flight.
// ----------------------------------------------------------------------------
module pid_antiwindup_controller_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_wr_en,
  input  logic [pidaw_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pidaw_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [15:0]                 measurement,
  input  logic                               clear_state,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 drive_value,
  output logic [1:0]                         clamp_status
);

  // Configuration registers
  logic [15:0]        gain_prop;
  logic [15:0]        gain_int_step;
  logic [15:0]        gain_deriv_step;
  logic signed [15:0] target_value;
  logic signed [15:0] drive_floor;
  logic signed [15:0] drive_ceiling;

  // Controller state
  logic signed [pidaw_pkg::SUM_W-1:0] error_sum;
  logic signed [pidaw_pkg::ERR_W-1:0] previous_error;

  // Input register
  logic               item_valid;
  logic signed [15:0] item_meas;
  logic               item_clear;

  // Handshake
  logic in_xfer;
  logic out_free;
  logic item_advance;

  // Datapath
  logic signed [pidaw_pkg::ERR_W-1:0]   err;
  logic signed [pidaw_pkg::SUM_W:0]     sum_wide;
  logic signed [pidaw_pkg::SUM_W-1:0]   sum_next;
  logic signed [pidaw_pkg::DIFF_W-1:0]  err_diff;
  logic signed [33:0]                   prod_p;
  logic signed [48:0]                   prod_i;
  logic signed [34:0]                   prod_d;
  logic signed [pidaw_pkg::TOTAL_W-1:0] total;
  logic signed [pidaw_pkg::TOTAL_W-1:0] ceil_q;
  logic signed [pidaw_pkg::TOTAL_W-1:0] floor_q;
  logic signed [15:0]                   drive_next;
  pidaw_pkg::clamp_status_t             status_next;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop       <= '0;
      gain_int_step   <= '0;
      gain_deriv_step <= '0;
      target_value    <= '0;
      drive_floor     <= '0;
      drive_ceiling   <= pidaw_pkg::CEILING_RESET;
    end else if (cfg_wr_en) begin
      case (pidaw_pkg::reg_index_t'(cfg_index))
        pidaw_pkg::REG_GAIN_PROP:       gain_prop       <= cfg_data;
        pidaw_pkg::REG_GAIN_INT_STEP:   gain_int_step   <= cfg_data;
        pidaw_pkg::REG_GAIN_DERIV_STEP: gain_deriv_step <= cfg_data;
        pidaw_pkg::REG_TARGET_VALUE:    target_value    <= cfg_data;
        pidaw_pkg::REG_DRIVE_FLOOR:     drive_floor     <= cfg_data;
        pidaw_pkg::REG_DRIVE_CEILING:   drive_ceiling   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: clear items never wait for the output register
  assign out_free     = !out_valid || !out_stall;
  assign item_advance = item_valid && (item_clear || out_free);
  assign in_stall     = item_valid && !item_advance;
  assign in_xfer      = in_valid && !in_stall;

  // Input register: load on transfer, drop when the item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_xfer) begin
      item_valid <= 1'b1;
    end else if (item_advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_meas  <= measurement;
      item_clear <= clear_state;
    end
  end

  // Error and saturating sum
  always_comb begin
    err      = {target_value[15], target_value} - {item_meas[15], item_meas};
    sum_wide = {error_sum[pidaw_pkg::SUM_W-1], error_sum}
             + {{(pidaw_pkg::SUM_W+1-pidaw_pkg::ERR_W){err[pidaw_pkg::ERR_W-1]}}, err};
    if (sum_wide[pidaw_pkg::SUM_W] != sum_wide[pidaw_pkg::SUM_W-1]) begin
      sum_next = sum_wide[pidaw_pkg::SUM_W] ? pidaw_pkg::SUM_MIN : pidaw_pkg::SUM_MAX;
    end else begin
      sum_next = sum_wide[pidaw_pkg::SUM_W-1:0];
    end
    err_diff = {err[pidaw_pkg::ERR_W-1], err}
             - {previous_error[pidaw_pkg::ERR_W-1], previous_error};
  end

  // Gain products and Q35.16 total
  always_comb begin
    prod_p = 34'(signed'({1'b0, gain_prop}))       * 34'(err);
    prod_i = 49'(signed'({1'b0, gain_int_step}))   * 49'(sum_next);
    prod_d = 35'(signed'({1'b0, gain_deriv_step})) * 35'(err_diff);
    total  = pidaw_pkg::TOTAL_W'(prod_p) + pidaw_pkg::TOTAL_W'(prod_i)
           + pidaw_pkg::TOTAL_W'(prod_d);
  end

  // Clamp: ceiling is tested first
  always_comb begin
    ceil_q  = {{(pidaw_pkg::TOTAL_W-16-pidaw_pkg::FRAC_W){drive_ceiling[15]}},
               drive_ceiling, {pidaw_pkg::FRAC_W{1'b0}}};
    floor_q = {{(pidaw_pkg::TOTAL_W-16-pidaw_pkg::FRAC_W){drive_floor[15]}},
               drive_floor, {pidaw_pkg::FRAC_W{1'b0}}};
    priority if (total > ceil_q) begin
      drive_next  = drive_ceiling;
      status_next = pidaw_pkg::CLAMP_CEILING;
    end else if (total < floor_q) begin
      drive_next  = drive_floor;
      status_next = pidaw_pkg::CLAMP_FLOOR;
    end else begin
      drive_next  = total[pidaw_pkg::FRAC_W+15:pidaw_pkg::FRAC_W];
      status_next = pidaw_pkg::CLAMP_NONE;
    end
  end

  // State update; hold the old sum on any clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (item_advance) begin
      if (item_clear) begin
        error_sum      <= '0;
        previous_error <= '0;
      end else begin
        previous_error <= err;
        if (status_next == pidaw_pkg::CLAMP_NONE) begin
          error_sum <= sum_next;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_advance && !item_clear) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_advance && !item_clear) begin
      drive_value  <= drive_next;
      clamp_status <= status_next;
    end
  end

endmodule

// ----- sv/pidaw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidaw_checker
// Port-level checks for the PID controller, bound to the controller unit.
// ----------------------------------------------------------------------------
module pidaw_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_wr_en,
  input logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [15:0]                drive_value,
  input logic [1:0]                        clamp_status
);

  // Shadow of the drive ceiling as written on the port
  logic signed [15:0] ceiling_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_shadow <= pidaw_pkg::CEILING_RESET;
    end else if (cfg_wr_en &&
                 cfg_index == pidaw_pkg::CFG_INDEX_W'(pidaw_pkg::REG_DRIVE_CEILING)) begin
      ceiling_shadow <= cfg_data;
    end
  end

  // A stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Input back-pressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // A new result needs a matching earlier input transfer
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching input transfer");

  // Ceiling clamp reports the configured ceiling
  a_ceiling_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp_status == pidaw_pkg::CLAMP_CEILING |-> drive_value == ceiling_shadow)
    else $error("ceiling clamp drives the wrong value");

endmodule

bind pid_antiwindup_controller_unit pidaw_checker u_pidaw_checker (
  .clk          (clk),
  .rst          (rst),
  .cfg_wr_en    (cfg_wr_en),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .drive_value  (drive_value),
  .clamp_status (clamp_status)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
// Measurements go in through the valid/stall input channel while a local
// predictor keeps its own gains, limits, error sum and previous error and
// queues the expected drive and clamp status for every non-clear item.
// Each transfer on the result channel is checked against the oldest entry.
// Directed tests cover reset values, gain and measurement extremes, the
// derivative path, the ceiling-before-floor order and large error sums
// in both directions; random phases then sweep settings with random gaps on
// the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned END_CYCLES     = 8;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SUM_RUN        = 16;
  localparam int unsigned RAND_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS    = 80;
  localparam int unsigned REPORT_LINES   = 100;
  localparam longint     Q_ONE           = 64'sd65536;

  // Register indexes that the block ignores
  localparam logic [pidaw_pkg::CFG_INDEX_W-1:0] CFG_INDEX_SPARE_A = 3'd6;
  localparam logic [pidaw_pkg::CFG_INDEX_W-1:0] CFG_INDEX_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [15:0]       drive;
    pidaw_pkg::clamp_status_t status;
  } drive_result_t;

  logic                              clk          = 1'b0;
  logic                              rst          = 1'b1;
  logic                              cfg_wr_en    = 1'b0;
  logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [pidaw_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
  logic                              in_valid     = 1'b0;
  logic                              in_stall;
  logic signed [15:0]                measurement  = '0;
  logic                              clear_state  = 1'b0;
  logic                              out_valid;
  logic                              out_stall    = 1'b0;
  logic signed [15:0]                drive_value;
  logic [1:0]                        clamp_status;

  // Predictor copy of the registers and the loop state
  logic [15:0]        cfg_kp      = '0;
  logic [15:0]        cfg_ki      = '0;
  logic [15:0]        cfg_kd      = '0;
  logic signed [15:0] cfg_target  = '0;
  logic signed [15:0] cfg_floor   = '0;
  logic signed [15:0] cfg_ceiling = pidaw_pkg::CEILING_RESET;
  logic signed [31:0] err_sum     = '0;
  logic signed [16:0] prev_err    = '0;

  drive_result_t pending_drives[$];
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles    = 0;
  int unsigned   stall_hold     = 0;
  bit            idle_en        = 1'b1;
  bit            stall_en       = 1'b1;

  pid_antiwindup_controller_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .measurement  (measurement),
    .clear_state  (clear_state),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_value  (drive_value),
    .clamp_status (clamp_status)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_LINES) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // Work out one PID step and queue the drive it must produce
  function automatic void compute_drive(input logic signed [15:0] meas, input logic clr);
    longint        err;
    longint        sum_next;
    longint        total;
    drive_result_t res;
    if (clr) begin
      err_sum  = '0;
      prev_err = '0;
      return;
    end
    err      = longint'(cfg_target) - longint'(meas);
    sum_next = longint'(err_sum) + err;
    if (sum_next > longint'(pidaw_pkg::SUM_MAX)) sum_next = longint'(pidaw_pkg::SUM_MAX);
    if (sum_next < longint'(pidaw_pkg::SUM_MIN)) sum_next = longint'(pidaw_pkg::SUM_MIN);
    total = longint'(cfg_kp) * err + longint'(cfg_ki) * sum_next
          + longint'(cfg_kd) * (err - longint'(prev_err));
    // Ceiling wins over floor; hold the sum on any clamp
    if (total > longint'(cfg_ceiling) * Q_ONE) begin
      res.drive  = cfg_ceiling;
      res.status = pidaw_pkg::CLAMP_CEILING;
    end else if (total < longint'(cfg_floor) * Q_ONE) begin
      res.drive  = cfg_floor;
      res.status = pidaw_pkg::CLAMP_FLOOR;
    end else begin
      res.drive  = 16'(total >>> pidaw_pkg::FRAC_W);
      res.status = pidaw_pkg::CLAMP_NONE;
      err_sum    = 32'(sum_next);
    end
    prev_err = 17'(err);
    pending_drives.push_back(res);
  endfunction

  // Random stall on the result side
  always @(posedge clk) begin
    if (!stall_en) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 9) < 3);
      stall_hold <= pick_gap();
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        report_mismatch($sformatf("unexpected result drive=%0d status=%0d",
                                  drive_value, clamp_status));
      end else begin
        want = pending_drives.pop_front();
        if (drive_value !== want.drive) begin
          report_mismatch($sformatf("drive_value got %0d expected %0d",
                                    drive_value, want.drive));
        end
        if (clamp_status !== want.status) begin
          report_mismatch($sformatf("clamp_status got %0d expected %0d",
                                    clamp_status, want.status));
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("pid_antiwindup_controller_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one register write; the caller lowers the enable
  task automatic write_cfg(input logic [pidaw_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      pidaw_pkg::REG_GAIN_PROP:       cfg_kp      = data;
      pidaw_pkg::REG_GAIN_INT_STEP:   cfg_ki      = data;
      pidaw_pkg::REG_GAIN_DERIV_STEP: cfg_kd      = data;
      pidaw_pkg::REG_TARGET_VALUE:    cfg_target  = data;
      pidaw_pkg::REG_DRIVE_FLOOR:     cfg_floor   = data;
      pidaw_pkg::REG_DRIVE_CEILING:   cfg_ceiling = data;
      default: ;
    endcase
  endtask

  // Write every register, plus one index the block must ignore
  task automatic apply_config(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic signed [15:0] tgt,
                              input logic signed [15:0] flr,
                              input logic signed [15:0] ceil);
    write_cfg(pidaw_pkg::REG_GAIN_PROP, kp);
    write_cfg(pidaw_pkg::REG_GAIN_INT_STEP, ki);
    write_cfg(pidaw_pkg::REG_GAIN_DERIV_STEP, kd);
    write_cfg(pidaw_pkg::REG_TARGET_VALUE, tgt);
    write_cfg(pidaw_pkg::REG_DRIVE_FLOOR, flr);
    write_cfg(pidaw_pkg::REG_DRIVE_CEILING, ceil);
    write_cfg($urandom_range(0, 1) ? CFG_INDEX_SPARE_A : CFG_INDEX_SPARE_B, 16'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(input logic signed [15:0] meas, input logic clr);
    int unsigned gap;
    gap = idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    measurement <= meas;
    clear_state <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_drive(meas, clr);
  endtask

  // Stop sending and let every expected result come out
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly near the setpoint, some full range, some extremes
  function automatic logic signed [15:0] rand_meas();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return cfg_target + 16'($urandom_range(0, 1024) - 512);
    if (r < 8) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  task automatic test_reset_values();
    send_item(16'sh0000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh1234, 1'b1);
    send_item(16'shFFFF, 1'b0);
    wait_results_done();
  endtask

  task automatic test_gain_extremes();
    apply_config(16'h0100, 16'h0000, 16'h0000, 16'sh0000, 16'sh8000, 16'sh7FFF);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'shFFFF, 1'b0);
    send_item(16'sh0001, 1'b0);
    wait_results_done();
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'($urandom), 1'b1);
    send_item(16'sh7FFF, 1'b0);
    wait_results_done();
  endtask

  task automatic test_derivative_windup();
    apply_config(16'h0080, 16'h0040, 16'h0200, 16'sh0A00, -16'sd50, 16'sd50);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh1400, 1'b0);
    send_item(16'sh0A00, 1'b0);
    send_item(16'shF600, 1'b0);
    wait_results_done();
  endtask

  task automatic test_limit_order();
    // Floor above ceiling: ceiling test decides first
    apply_config(16'h0100, 16'h0000, 16'h0000, 16'sh0000, 16'sd100, -16'sd100);
    send_item(16'sh8100, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'sh7F00, 1'b0);
    wait_results_done();
    // Equal limits: exact hit, one LSB over, one LSB under
    apply_config(16'h0100, 16'h0000, 16'h0000, 16'sh0000, 16'sd5, 16'sd5);
    send_item(16'shFB00, 1'b0);
    send_item(16'shFAFF, 1'b0);
    send_item(16'shFB01, 1'b0);
    wait_results_done();
  endtask

  task automatic test_large_sum();
    idle_en  = 1'b0;
    stall_en = 1'b0;
    // Build a large positive sum with all gains at zero
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    repeat (SUM_RUN) send_item(16'sh8000, 1'b0);
    wait_results_done();
    apply_config(16'h0000, 16'h0001, 16'h0000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh0000, 1'b1);
    send_item(16'sh7FFF, 1'b0);
    wait_results_done();
    // Same toward a large negative sum
    apply_config(16'h0000, 16'h0000, 16'h0000, 16'sh8000, 16'sh8000, 16'sh7FFF);
    repeat (SUM_RUN) send_item(16'sh7FFF, 1'b0);
    wait_results_done();
    apply_config(16'h0000, 16'h0001, 16'h0000, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8100, 1'b0);
    wait_results_done();
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  task automatic test_random_phases();
    logic signed [15:0] flr;
    logic signed [15:0] ceil;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom), 16'sh8000, 16'sh7FFF);
        1: apply_config(16'h0000, 16'h0000, 16'h0000, 16'sh7FFF, 16'sh0000,
                        pidaw_pkg::CEILING_RESET);
        2: apply_config(16'($urandom_range(0, 512)), 16'($urandom_range(0, 32)),
                        16'($urandom_range(0, 256)), 16'($urandom), 16'sh7FFF, 16'sh8000);
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            flr  = 16'($urandom);
            ceil = 16'($urandom);
          end else begin
            flr  = 16'(-int'($urandom_range(0, 3000)));
            ceil = 16'($urandom_range(0, 3000));
          end
          apply_config(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 48)),
                       16'($urandom_range(0, 512)), 16'($urandom), flr, ceil);
        end
      endcase
      idle_en  = (p % 3 != 1);
      stall_en = (p % 4 != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Pause the sender once until the pipe is empty
        if (p == 3 && n == PHASE_ITEMS / 2) wait_results_done();
        send_item(rand_meas(), ($urandom_range(0, 29) == 0));
      end
      wait_results_done();
    end
    idle_en  = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_gain_extremes();
    test_derivative_windup();
    test_limit_order();
    test_large_sum();
    test_random_phases();
    wait_results_done();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pid_antiwindup_controller_unit verification clean");
    end else begin
      $display("pid_antiwindup_controller_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pidaw_pkg.sv
sv/pid_antiwindup_controller_unit.sv
sv/pidaw_checker.sv
tb/sv/tb.sv
